[hdl/psq_pkg.sv]
// Package for the policy select queue: item structs, status, policy and
// register codes, default sizes. No dependencies.
package psq_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned DataWidthDef = 32;

  localparam int unsigned PRIO_W = 8;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned OCC_W = 5;
  localparam int unsigned POL_W = 2;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned REG_DATA_W = 8;

  localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POL_W-1:0] POL_LIFO = 2'd1;
  localparam logic [POL_W-1:0] POL_PRIO = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_CEILING = 1'b1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic                     operation;
    logic [PAY_W-1:0]         payload;
    logic signed [PRIO_W-1:0] entry_priority;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [PAY_W-1:0] popped_payload;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

endpackage

[hdl/psq_store.sv]
// Entry store: payload and priority per slot, one write and one registered
// read port. Depends on psq_pkg for the priority width.
module psq_store #(
  parameter int unsigned DEPTH = psq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = psq_pkg::DataWidthDef,
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [IW-1:0]                    waddr_i,
  input  logic [DATA_WIDTH-1:0]            wdata_i,
  input  logic signed [psq_pkg::PRIO_W-1:0] wprio_i,
  input  logic [IW-1:0]                    raddr_i,
  output logic [DATA_WIDTH-1:0]            rdata_o,
  output logic signed [psq_pkg::PRIO_W-1:0] rprio_o
);
  import psq_pkg::*;

  logic [DATA_WIDTH-1:0]     pay_mem [DEPTH];
  logic signed [PRIO_W-1:0]  prio_mem [DEPTH];
  logic [DATA_WIDTH-1:0]     rdata_q;
  logic signed [PRIO_W-1:0]  rprio_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pay_mem[waddr_i] <= wdata_i;
      prio_mem[waddr_i] <= wprio_i;
    end
    rdata_q <= pay_mem[raddr_i];
    rprio_q <= prio_mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign rprio_o = rprio_q;

endmodule

[hdl/psq_seq.sv]
// Sequencer: one signed compare unit shared by the clamp and the priority
// scan, entry count, selection and compaction. Depends on psq_pkg.
module psq_seq #(
  parameter int unsigned DEPTH = psq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = psq_pkg::DataWidthDef,
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  input  psq_pkg::in_item_t                 item_i,
  output logic                              item_ready_o,
  input  logic [psq_pkg::POL_W-1:0]         policy_i,
  input  logic signed [psq_pkg::PRIO_W-1:0] ceiling_i,
  output logic                              res_valid_o,
  input  logic                              res_taken_i,
  output psq_pkg::out_item_t                res_o,
  output logic                              mem_we_o,
  output logic [IW-1:0]                     mem_waddr_o,
  output logic [DATA_WIDTH-1:0]             mem_wdata_o,
  output logic signed [psq_pkg::PRIO_W-1:0] mem_wprio_o,
  output logic [IW-1:0]                     mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]             mem_rdata_i,
  input  logic signed [psq_pkg::PRIO_W-1:0] mem_rprio_i
);
  import psq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PUSH     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_FETCH_RD = 4'd4;
  localparam logic [3:0] S_FETCH    = 4'd5;
  localparam logic [3:0] S_SHIFT_RD = 4'd6;
  localparam logic [3:0] S_SHIFT_WR = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]               state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            sel_q, sel_d;
  logic [CW-1:0]            idx_inc;
  logic signed [PRIO_W-1:0] best_q, best_d;
  logic [DATA_WIDTH-1:0]    pay_q, pay_d;
  logic signed [PRIO_W-1:0] prio_q, prio_d;
  logic [DATA_WIDTH-1:0]    popped_q, popped_d;
  status_e                  status_q, status_d;
  logic signed [PRIO_W-1:0] cmp_a, cmp_b;
  logic                     cmp_gt;

  assign idx_inc = idx_q + CW'(1);

  // shared compare unit
  always_comb begin
    if (state_q == S_PUSH) begin
      cmp_a = prio_q;
      cmp_b = ceiling_i;
    end else begin
      cmp_a = mem_rprio_i;
      cmp_b = best_q;
    end
  end
  assign cmp_gt = cmp_a > cmp_b;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d = idx_q;
    sel_d = sel_q;
    best_d = best_q;
    pay_d = pay_q;
    prio_d = prio_q;
    popped_d = popped_q;
    status_d = status_q;
    mem_we_o = 1'b0;
    mem_waddr_o = count_q[IW-1:0];
    mem_wdata_o = pay_q;
    mem_wprio_o = prio_q;
    mem_raddr_o = idx_q[IW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          pay_d = DATA_WIDTH'(item_i.payload);
          prio_d = item_i.entry_priority;
          popped_d = '0;
          if (item_i.operation == OP_PUSH) begin
            if (count_q == CW'(DEPTH)) begin
              status_d = ST_FULL;
              state_d = S_DONE;
            end else begin
              state_d = S_PUSH;
            end
          end else if (count_q == '0) begin
            status_d = ST_EMPTY;
            state_d = S_DONE;
          end else if (policy_i == POL_PRIO) begin
            idx_d = '0;
            sel_d = '0;
            state_d = S_SCAN_RD;
          end else if (policy_i == POL_LIFO) begin
            sel_d = count_q - CW'(1);
            state_d = S_FETCH_RD;
          end else begin
            sel_d = '0;
            state_d = S_FETCH_RD;
          end
        end
      end
      S_PUSH: begin
        mem_we_o = 1'b1;
        mem_wprio_o = cmp_gt ? ceiling_i : prio_q;
        count_d = count_q + CW'(1);
        status_d = ST_PUSHED;
        state_d = S_DONE;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (idx_q == '0 || cmp_gt) begin
          best_d = mem_rprio_i;
          sel_d = idx_q;
        end
        idx_d = idx_inc;
        state_d = (idx_inc == count_q) ? S_FETCH_RD : S_SCAN_RD;
      end
      S_FETCH_RD: begin
        mem_raddr_o = sel_q[IW-1:0];
        state_d = S_FETCH;
      end
      S_FETCH: begin
        popped_d = mem_rdata_i;
        idx_d = sel_q;
        state_d = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (idx_inc >= count_q) begin
          count_d = count_q - CW'(1);
          status_d = ST_POPPED;
          state_d = S_DONE;
        end else begin
          mem_raddr_o = idx_inc[IW-1:0];
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        mem_we_o = 1'b1;
        mem_waddr_o = idx_q[IW-1:0];
        mem_wdata_o = mem_rdata_i;
        mem_wprio_o = mem_rprio_i;
        idx_d = idx_inc;
        state_d = S_SHIFT_RD;
      end
      S_DONE: begin
        if (res_taken_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    sel_q <= sel_d;
    best_q <= best_d;
    pay_q <= pay_d;
    prio_q <= prio_d;
    popped_q <= popped_d;
    status_q <= status_d;
  end

  assign item_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign res_o.popped_payload = PAY_W'(popped_q);
  assign res_o.occupancy = OCC_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_PUSH || state_q == S_SHIFT_WR))
    else $error("store written outside push or shift");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSH |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not advance count");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_taken_i) |=> (state_q == S_DONE && $stable(count_q)))
    else $error("result dropped before taken");

endmodule

[hdl/policy_select_queue_unit.sv]
// Top level of the policy select queue: configuration registers, output
// register, sequencer and entry store. Depends on psq_pkg, psq_seq, psq_store.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o   | in_item_i  (psq_pkg::in_item_t)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (psq_pkg::out_item_t)
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// Pop: reads slot s, the selected one of the n entries held, then shifts each
// entry above s down one slot; the priority policy first scans all n entries
// through the single store read port.
// Reset clears count, state, config and out_valid; the store needs no clearing pass.
// in_stall_o is high while an item is in work; a waiting result holds only
// the next finished result, not the next accept.
module policy_select_queue_unit #(
  parameter int unsigned DEPTH = psq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = psq_pkg::DataWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  psq_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output psq_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_we_i,
  input  logic [psq_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [psq_pkg::REG_DATA_W-1:0]      cfg_data_i
);
  import psq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  logic [POL_W-1:0]          policy_q;
  logic signed [PRIO_W-1:0]  ceiling_q;
  logic                      out_valid_q;
  out_item_t                 out_item_q;
  logic                      item_ready;
  logic                      res_valid;
  logic                      res_taken;
  out_item_t                 res_item;
  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  logic [DATA_WIDTH-1:0]     mem_wdata;
  logic signed [PRIO_W-1:0]  mem_wprio;
  logic [IW-1:0]             mem_raddr;
  logic [DATA_WIDTH-1:0]     mem_rdata;
  logic signed [PRIO_W-1:0]  mem_rprio;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIFO;
      ceiling_q <= 8'sd127;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLICY:  policy_q <= cfg_data_i[POL_W-1:0];
        REG_CEILING: ceiling_q <= $signed(cfg_data_i[PRIO_W-1:0]);
        default: ;
      endcase
    end
  end

  assign res_taken = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_taken) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_taken) begin
      out_item_q <= res_item;
    end
  end

  psq_seq #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_seq (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .item_valid_i(in_valid_i),
    .item_i(in_item_i),
    .item_ready_o(item_ready),
    .policy_i(policy_q),
    .ceiling_i(ceiling_q),
    .res_valid_o(res_valid),
    .res_taken_i(res_taken),
    .res_o(res_item),
    .mem_we_o(mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_wprio_o(mem_wprio),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .mem_rprio_i(mem_rprio)
  );

  psq_store #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_store (
    .clk_i(clk_i),
    .we_i(mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .wprio_i(mem_wprio),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata),
    .rprio_o(mem_rprio)
  );

  assign in_stall_o = !item_ready;
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

endmodule
